/* hw/rtl/ole_pkg.sv */
// shared types and constants of the ordered list engine
package ole_pkg;

	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int CNT_W = 7;
	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [1:0] {
		OP_FRONT  = 2'd0,
		OP_REAR   = 2'd1,
		OP_DELETE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic push_front;
		logic append;
		logic pull;
	} cell_cmd_t;

endpackage

/* hw/rtl/ole_cell.sv */
// one storage cell of the list chain with its compare and shift logic
module ole_cell #(
	parameter int IDX = 0,
	parameter int CW = 7
) (
	input  logic                            clk,
	input  logic                            ld,
	input  logic signed [ole_pkg::VAL_W-1:0] in_key,
	input  logic [ole_pkg::POS_W-1:0]       in_pos,
	input  logic [CW-1:0]                   cnt,
	input  ole_pkg::cell_cmd_t              cmd,
	input  logic signed [ole_pkg::VAL_W-1:0] ins_val,
	input  logic signed [ole_pkg::VAL_W-1:0] left_val,
	input  logic signed [ole_pkg::VAL_W-1:0] right_val,
	output logic signed [ole_pkg::VAL_W-1:0] val_q,
	output logic                            match_s1,
	output logic                            sel_s1
);

	logic after_s1;
	logic tail_s1;

	always_ff @(posedge clk) begin
		if (ld) begin
			match_s1 <= (IDX < 32'(cnt)) && (val_q == in_key);
			sel_s1   <= (32'(in_pos) == IDX + 1);
			after_s1 <= (32'(in_pos) <= IDX + 1);
			tail_s1  <= (32'(cnt) == IDX);
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.push_front) begin
			val_q <= left_val;
		end else if (cmd.append && tail_s1) begin
			val_q <= ins_val;
		end else if (cmd.pull && after_s1) begin
			val_q <= right_val;
		end
	end

endmodule

/* hw/rtl/ole_pick.sv */
// first-match encoder and selected-cell readout across the chain
module ole_pick #(
	parameter int N = 64,
	parameter int W = 32,
	parameter int IW = 6
) (
	input  logic [N-1:0]  match,
	input  logic [N-1:0]  sel,
	input  logic [W-1:0]  vals [N],
	output logic          hit,
	output logic [IW-1:0] idx,
	output logic [W-1:0]  sel_val
);

	logic [N-1:0] first;

	assign first = match & (~match + N'(1));
	assign hit = |match;

	always_comb begin
		idx = '0;
		sel_val = '0;
		for (int i = 0; i < N; i++) begin
			if (first[i]) begin
				idx = idx | IW'(i);
			end
			if (sel[i]) begin
				sel_val = sel_val | vals[i];
			end
		end
	end

endmodule

/* hw/rtl/ordered_list_engine.sv */
// ordered list engine: a bounded ordered store kept in a chain of cells
//
// s_* carries requests: insert front, insert rear, delete at a 1-based
// position, or search for a key. m_* carries exactly one result for each.
// a request is taken while the engine is idle; every cell compares its
// value and its index at that edge. the execute state then reduces the
// flags, updates the cells (a front insert shifts all of them one place,
// a rear insert fills the tail, a delete shifts those after it back) and
// loads the result register when it is free. a request makes one compare
// and shift pass through the cell row; the next is taken after it commits.
// the result register lets a new request in while the previous result
// waits; if the receiver stalls, the following request is held in its
// shift cycle until the result register frees up.
// reset empties the list (count zero); cell contents are left as they are
// and only occupied cells are ever read.
module ordered_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation[1:0], value[33:2], position[40:34], zero fill
	input  logic [ole_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status[2:0], removed_value[34:3], found_position[41:35],
	// entry_count[48:42], zero fill
	output logic [ole_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int CMPW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;
	localparam int VW = ole_pkg::VAL_W;

	ole_pkg::fsm_t    state_q, state_nxt;
	ole_pkg::op_t     op_s1;
	logic signed [VW-1:0] key_s1;
	logic [ole_pkg::POS_W-1:0] pos_s1;
	logic [CW-1:0]    count_q, count_nxt;
	logic             m_tvalid_q;
	logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic accept, out_free, commit, full;
	ole_pkg::status_t status;
	logic signed [VW-1:0] removed;
	logic [CW-1:0]    found;
	ole_pkg::cell_cmd_t cmd;

	logic signed [VW-1:0] in_value;
	logic [ole_pkg::POS_W-1:0] in_pos;

	logic signed [VW-1:0] cell_val [CAPACITY];
	logic [VW-1:0]    pick_val [CAPACITY];
	logic [CAPACITY-1:0] match_v, sel_v;
	logic             pk_hit;
	logic [IW-1:0]    pk_idx;
	logic [VW-1:0]    pk_sel_val;

	assign in_value = s_tdata[VW+1:2];
	assign in_pos = s_tdata[VW+ole_pkg::POS_W+1:VW+2];

	assign s_tready = (state_q == ole_pkg::FSM_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit = (state_q == ole_pkg::FSM_EXEC) && out_free;
	assign full = (count_q == CW'(CAPACITY));

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic signed [VW-1:0] left_val, right_val;
			if (g == 0) begin : g_head
				assign left_val = key_s1;
			end else begin : g_body
				assign left_val = cell_val[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign right_val = cell_val[g];
			end else begin : g_mid
				assign right_val = cell_val[g+1];
			end
			ole_cell #(
				.IDX(g),
				.CW(CW)
			) u_cell (
				.clk(clk),
				.ld(accept),
				.in_key(in_value),
				.in_pos(in_pos),
				.cnt(count_q),
				.cmd(cmd),
				.ins_val(key_s1),
				.left_val(left_val),
				.right_val(right_val),
				.val_q(cell_val[g]),
				.match_s1(match_v[g]),
				.sel_s1(sel_v[g])
			);
			assign pick_val[g] = cell_val[g];
		end
	endgenerate

	ole_pick #(
		.N(CAPACITY),
		.W(VW),
		.IW(IW)
	) u_pick (
		.match(match_v),
		.sel(sel_v),
		.vals(pick_val),
		.hit(pk_hit),
		.idx(pk_idx),
		.sel_val(pk_sel_val)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ole_pkg::FSM_IDLE: begin
				if (accept) begin
					state_nxt = ole_pkg::FSM_EXEC;
				end
			end
			ole_pkg::FSM_EXEC: begin
				if (out_free) begin
					state_nxt = ole_pkg::FSM_IDLE;
				end
			end
			default: state_nxt = ole_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		status = ole_pkg::ST_OK;
		removed = '0;
		found = '0;
		count_nxt = count_q;
		cmd = '0;
		unique case (op_s1)
			ole_pkg::OP_FRONT, ole_pkg::OP_REAR: begin
				if (full) begin
					status = ole_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + CW'(1);
					cmd.push_front = commit && (op_s1 == ole_pkg::OP_FRONT);
					cmd.append = commit && (op_s1 == ole_pkg::OP_REAR);
				end
			end
			ole_pkg::OP_DELETE: begin
				priority if (count_q == '0) begin
					status = ole_pkg::ST_EMPTY;
				end else if (pos_s1 == '0 || CMPW'(pos_s1) > CMPW'(count_q)) begin
					status = ole_pkg::ST_BADPOS;
				end else begin
					removed = pk_sel_val;
					count_nxt = count_q - CW'(1);
					cmd.pull = commit;
				end
			end
			ole_pkg::OP_SEARCH: begin
				priority if (count_q == '0) begin
					status = ole_pkg::ST_EMPTY;
				end else if (!pk_hit) begin
					status = ole_pkg::ST_NOTFOUND;
				end else begin
					found = CW'(pk_idx) + CW'(1);
				end
			end
			default: status = ole_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ole_pkg::FSM_IDLE;
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (commit) begin
				count_q <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= ole_pkg::op_t'(s_tdata[1:0]);
			key_s1 <= in_value;
			pos_s1 <= in_pos;
		end
		if (commit) begin
			m_tdata_q <= {7'd0, ole_pkg::CNT_W'(count_nxt), ole_pkg::POS_W'(found),
				removed, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ole_pkg::FSM_EXEC)
		else $error("request taken without an execute cycle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ole_pkg::FSM_EXEC))
		else $error("result raised outside an execute cycle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(commit) &&
			(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one or outside a commit");
`endif

endmodule

/* test/tb_ordered_list_engine.sv */
// testbench for the ordered list engine: directed table, then phased random requests
`timescale 1ns / 100ps

module tb_ordered_list_engine;

	localparam int LIST_CAP = 64;
	localparam int RANDOM_REQUESTS = 650;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		ole_pkg::status_t status;
		logic [31:0] removed;
		logic [6:0]  found;
		logic [6:0]  count;
	} list_result_t;

	typedef struct packed {
		ole_pkg::op_t op;
		logic [31:0]  value;
		logic [6:0]   position;
		logic         typed;
		list_result_t result;
	} directed_row_t;

	typedef enum logic [1:0] {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata;

	logic [31:0]  shadow_list[$];
	list_result_t pending_results[$];
	list_result_t got_result;
	list_result_t want_result;
	bit           steady_flow;
	int           requests_sent;
	int           results_checked;
	int           mismatches;
	int           status_hits[5];

	directed_row_t directed_plan [24] = '{
		'{ole_pkg::OP_SEARCH, 32'h0,        7'd0,   1'b1,
			'{ole_pkg::ST_EMPTY,    32'h0, 7'd0, 7'd0}},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd1,   1'b1,
			'{ole_pkg::ST_EMPTY,    32'h0, 7'd0, 7'd0}},
		'{ole_pkg::OP_DELETE, 32'hffffffff, 7'd127, 1'b1,
			'{ole_pkg::ST_EMPTY,    32'h0, 7'd0, 7'd0}},
		'{ole_pkg::OP_FRONT,  32'h7fffffff, 7'd0,   1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd1}},
		'{ole_pkg::OP_REAR,   32'h80000000, 7'd127, 1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd2}},
		'{ole_pkg::OP_FRONT,  32'hffffffff, 7'd0,   1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd3}},
		'{ole_pkg::OP_REAR,   32'h0,        7'd0,   1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd4}},
		'{ole_pkg::OP_REAR,   32'h7fffffff, 7'd0,   1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd5}},
		'{ole_pkg::OP_SEARCH, 32'h7fffffff, 7'd0,   1'b0, '0},
		'{ole_pkg::OP_SEARCH, 32'h80000000, 7'd0,   1'b0, '0},
		'{ole_pkg::OP_SEARCH, 32'h12345678, 7'd0,   1'b1,
			'{ole_pkg::ST_NOTFOUND, 32'h0, 7'd0, 7'd5}},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd0,   1'b1,
			'{ole_pkg::ST_BADPOS,   32'h0, 7'd0, 7'd5}},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd6,   1'b1,
			'{ole_pkg::ST_BADPOS,   32'h0, 7'd0, 7'd5}},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd127, 1'b1,
			'{ole_pkg::ST_BADPOS,   32'h0, 7'd0, 7'd5}},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd5,   1'b0, '0},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd1,   1'b0, '0},
		'{ole_pkg::OP_SEARCH, 32'h0,        7'd0,   1'b0, '0},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd2,   1'b0, '0},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd1,   1'b0, '0},
		'{ole_pkg::OP_DELETE, 32'h0,        7'd1,   1'b0, '0},
		'{ole_pkg::OP_SEARCH, 32'h5,        7'd0,   1'b1,
			'{ole_pkg::ST_EMPTY,    32'h0, 7'd0, 7'd0}},
		'{ole_pkg::OP_REAR,   32'h55555555, 7'd42,  1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd1}},
		'{ole_pkg::OP_FRONT,  32'haaaaaaaa, 7'd85,  1'b1,
			'{ole_pkg::ST_OK,       32'h0, 7'd0, 7'd2}},
		'{ole_pkg::OP_SEARCH, 32'h55555555, 7'd0,   1'b0, '0}
	};

	ordered_list_engine #(
		.CAPACITY(LIST_CAP)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_result_t apply_list_op(ole_pkg::op_t op, logic [31:0] key,
			logic [6:0] pos);
		list_result_t r;
		int hit;
		r = '0;
		r.status = ole_pkg::ST_OK;
		hit = 0;
		case (op)
			ole_pkg::OP_FRONT, ole_pkg::OP_REAR: begin
				if (shadow_list.size() >= LIST_CAP) begin
					r.status = ole_pkg::ST_FULL;
				end else if (op == ole_pkg::OP_FRONT) begin
					shadow_list.push_front(key);
				end else begin
					shadow_list.push_back(key);
				end
			end
			ole_pkg::OP_DELETE: begin
				if (shadow_list.size() == 0) begin
					r.status = ole_pkg::ST_EMPTY;
				end else if (pos == 0 || pos > shadow_list.size()) begin
					r.status = ole_pkg::ST_BADPOS;
				end else begin
					r.removed = shadow_list[pos - 1];
					shadow_list.delete(pos - 1);
				end
			end
			default: begin
				if (shadow_list.size() == 0) begin
					r.status = ole_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < shadow_list.size() && hit == 0; i++) begin
						if (shadow_list[i] == key)
							hit = i + 1;
					end
					if (hit == 0)
						r.status = ole_pkg::ST_NOTFOUND;
					else
						r.found = hit[6:0];
				end
			end
		endcase
		r.count = 7'(shadow_list.size());
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return $urandom;
		if (roll < 75 && shadow_list.size() != 0)
			return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		case ($urandom_range(0, 6))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'hffffffff;
			3: return 32'hfffffffe;
			4: return 32'h1;
			5: return 32'h2;
			default: return 32'h0;
		endcase
	endfunction

	task automatic send_request(ole_pkg::op_t op, logic [31:0] val, logic [6:0] pos,
			logic typed, list_result_t typed_result);
		list_result_t predicted;
		if (!steady_flow && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, pos, val, op};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		predicted = apply_list_op(op, val, pos);
		pending_results.push_back(typed ? typed_result : predicted);
		requests_sent++;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, list_result_t want, list_result_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t: %s: expected status %0d removed %h found %0d count %0d",
				$realtime, what, want.status, want.removed, want.found, want.count);
			$display("%0t: %s: got status %0d removed %h found %0d count %0d",
				$realtime, what, got.status, got.removed, got.found, got.count);
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_result.status = ole_pkg::status_t'(m_tdata[2:0]);
			got_result.removed = m_tdata[34:3];
			got_result.found = m_tdata[41:35];
			got_result.count = m_tdata[48:42];
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", '0, got_result);
			end else begin
				want_result = pending_results.pop_front();
				results_checked++;
				status_hits[want_result.status]++;
				if (got_result.status !== want_result.status
						|| got_result.removed !== want_result.removed
						|| got_result.found !== want_result.found
						|| got_result.count !== want_result.count)
					report_mismatch("result mismatch", want_result, got_result);
			end
		end
		m_tready <= steady_flow || ($urandom_range(0, 99) >= 24);
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results still pending", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		phase_t phase;
		ole_pkg::op_t op;
		logic [31:0] val;
		logic [6:0] pos;
		int roll;
		int over_edge;
		int mix_left;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		steady_flow = 1'b0;
		requests_sent = 0;
		results_checked = 0;
		mismatches = 0;
		phase = PH_FILL;
		over_edge = 0;
		mix_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			send_request(directed_plan[i].op, directed_plan[i].value, directed_plan[i].position,
				directed_plan[i].typed, directed_plan[i].result);
		hold_until_drained();

		for (int k = 0; k < RANDOM_REQUESTS; k++) begin
			steady_flow = (k >= 250 && k < 400);
			if (k % 160 == 80)
				hold_until_drained();
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				op = ole_pkg::op_t'($urandom_range(0, 3));
			end else begin
				roll = $urandom_range(0, 99);
				case (phase)
					PH_FILL:  op = ole_pkg::op_t'(roll < 80 ?
						($urandom_range(0, 1) ? ole_pkg::OP_FRONT : ole_pkg::OP_REAR) :
						roll < 95 ? ole_pkg::OP_SEARCH : ole_pkg::OP_DELETE);
					PH_DRAIN: op = ole_pkg::op_t'(roll < 75 ? ole_pkg::OP_DELETE :
						roll < 90 ? ole_pkg::OP_SEARCH :
						($urandom_range(0, 1) ? ole_pkg::OP_FRONT : ole_pkg::OP_REAR));
					default:  op = ole_pkg::op_t'(roll < 35 ?
						($urandom_range(0, 1) ? ole_pkg::OP_FRONT : ole_pkg::OP_REAR) :
						roll < 70 ? ole_pkg::OP_DELETE : ole_pkg::OP_SEARCH);
				endcase
			end
			val = pick_value();
			pos = 7'($urandom_range(0, 127));
			if (op == ole_pkg::OP_DELETE && shadow_list.size() != 0
					&& $urandom_range(0, 99) < 80)
				pos = 7'($urandom_range(1, shadow_list.size()));
			if (op == ole_pkg::OP_SEARCH && shadow_list.size() != 0
					&& $urandom_range(0, 99) < 70)
				val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
			send_request(op, val, pos, 1'b0, '0);

			case (phase)
				PH_FILL: begin
					if (shadow_list.size() == LIST_CAP && ++over_edge > 3) begin
						phase = PH_DRAIN;
						over_edge = 0;
					end
				end
				PH_DRAIN: begin
					if (shadow_list.size() == 0 && ++over_edge > 2) begin
						phase = PH_MIX;
						mix_left = $urandom_range(30, 60);
						over_edge = 0;
					end
				end
				default: begin
					if (--mix_left <= 0)
						phase = PH_FILL;
				end
			endcase
		end

		steady_flow = 1'b0;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d mismatches", requests_sent,
			results_checked, mismatches);
		$display("status mix: ok %0d, empty %0d, bad position %0d, not found %0d, full %0d",
			status_hits[ole_pkg::ST_OK], status_hits[ole_pkg::ST_EMPTY],
			status_hits[ole_pkg::ST_BADPOS], status_hits[ole_pkg::ST_NOTFOUND],
			status_hits[ole_pkg::ST_FULL]);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
